### design/cdo_pkg.sv
// shared types, constants and calendar functions for the calendar date offset unit
`timescale 1ns / 1ps
package cdo_pkg;

  localparam int CMD_W   = 2;
  localparam int CNT_W   = 13;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int STS_W   = 2;

  localparam int MAX_YEAR_DEF = 9999;

  // internal widths
  localparam int YEAR_IW = 17;
  localparam int SVAL_W  = 19;
  localparam int ORD_W   = 17;
  localparam int DIV_W   = 18;
  localparam int QUO_W   = 15;
  localparam int R_W     = 9;
  localparam int DLEN_W  = 9;

  localparam int R400_LAST  = 399;

  // reciprocals for the divide by 12 and the year modulo 400
  localparam int RECIP12    = 43691;
  localparam int RECIP12_SH = 17;
  localparam int P12_W      = 32;
  localparam int RECIP25    = 20972;
  localparam int RECIP25_SH = 19;
  localparam int P25_W      = 29;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_DAY   = 2'd0,
    CMD_WEEK  = 2'd1,
    CMD_MONTH = 2'd2,
    CMD_YEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_BAD_DATE = 2'd1,
    STS_BAD_UNIT = 2'd2,
    STS_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_BAD,
    K_DAYS,
    K_MONTHS,
    K_YEARS
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MOD,
    S_REM,
    S_POST,
    S_DIV,
    S_DIVDONE,
    S_WALK,
    S_MWALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    kind_e                    kind;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [YEAR_W-1:0]        year;
    logic signed [SVAL_W-1:0] sval;
  } item_t;

  // leap rule from the year modulo 400
  function automatic logic leap_of(input logic [R_W-1:0] r);
    leap_of = (r[1:0] == 2'b00) && (r != R_W'(100)) && (r != R_W'(200))
              && (r != R_W'(300));
  endfunction

  function automatic logic [DLEN_W-1:0] year_len(input logic leap);
    year_len = leap ? DLEN_W'(366) : DLEN_W'(365);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = DAY_W'(30);
      4'd2:                    month_len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                 month_len = DAY_W'(31);
    endcase
  endfunction

  // days in the year before the first of month m
  function automatic logic [DLEN_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DLEN_W-1:0] base;
    case (m)
      4'd1:    base = DLEN_W'(0);
      4'd2:    base = DLEN_W'(31);
      4'd3:    base = DLEN_W'(59);
      4'd4:    base = DLEN_W'(90);
      4'd5:    base = DLEN_W'(120);
      4'd6:    base = DLEN_W'(151);
      4'd7:    base = DLEN_W'(181);
      4'd8:    base = DLEN_W'(212);
      4'd9:    base = DLEN_W'(243);
      4'd10:   base = DLEN_W'(273);
      4'd11:   base = DLEN_W'(304);
      4'd12:   base = DLEN_W'(334);
      default: base = DLEN_W'(0);
    endcase
    days_before = (leap && (m > 4'd2)) ? base + DLEN_W'(1) : base;
  endfunction

endpackage

### design/cdo_front.sv
// front end: checks and classifies each date and prepares its offset
`timescale 1ns / 1ps
module cdo_front
  import cdo_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [CNT_W-1:0]  count_i,
  input  logic [MONTH_W-1:0]       in_month_i,
  input  logic [DAY_W-1:0]         in_day_i,
  input  logic [YEAR_W-1:0]        in_year_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output item_t                    push_item_o
);

  localparam logic [YEAR_IW-1:0] MaxU = YEAR_IW'(MAX_YEAR);

  logic                     bad;
  logic signed [SVAL_W-1:0] cnt_x;
  logic signed [SVAL_W-1:0] year_x;
  logic signed [SVAL_W-1:0] mon_x;
  logic signed [SVAL_W-1:0] year12;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    bad    = !(in_month_i inside {[4'd1 : 4'd12]}) || (in_day_i == '0)
             || ({{(YEAR_IW-YEAR_W){1'b0}}, in_year_i} > MaxU);
    cnt_x  = SVAL_W'(count_i);
    year_x = $signed({{(SVAL_W-YEAR_W){1'b0}}, in_year_i});
    mon_x  = $signed({{(SVAL_W-MONTH_W){1'b0}}, in_month_i}) - SVAL_W'(1);
    year12 = (year_x <<< 3) + (year_x <<< 2);

    push_item_o.month = in_month_i;
    push_item_o.day   = in_day_i;
    push_item_o.year  = in_year_i;
    push_item_o.kind  = K_BAD;
    push_item_o.sval  = cnt_x;
    if (!bad) begin
      case (cmd_e'(cmd_i))
        CMD_DAY: begin
          push_item_o.kind = K_DAYS;
          push_item_o.sval = cnt_x;
        end
        CMD_WEEK: begin
          push_item_o.kind = K_DAYS;
          push_item_o.sval = (cnt_x <<< 3) - cnt_x;
        end
        CMD_MONTH: begin
          push_item_o.kind = K_MONTHS;
          push_item_o.sval = year12 + mon_x + cnt_x;
        end
        CMD_YEAR: begin
          push_item_o.kind = K_YEARS;
          push_item_o.sval = year_x + cnt_x;
        end
        default: begin
          push_item_o.kind = K_BAD;
        end
      endcase
    end
  end

endmodule

### design/cdo_queue.sv
// short fifo of classified items between front end and back end
`timescale 1ns / 1ps
module cdo_queue
  import cdo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/cdo_back.sv
// back end: sequencer that walks years and months, divides and holds the result
`timescale 1ns / 1ps
module cdo_back
  import cdo_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  item_t               pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MONTH_W-1:0]  out_month_o,
  output logic [DAY_W-1:0]    out_day_o,
  output logic [YEAR_W-1:0]   out_year_o,
  output logic [STS_W-1:0]    status_o
);

  localparam logic [YEAR_IW-1:0]       MaxU = YEAR_IW'(MAX_YEAR);
  localparam logic signed [SVAL_W-1:0] MaxS = SVAL_W'(MAX_YEAR);

  state_e                   state_q, state_d;
  logic                     out_valid_q, out_valid_d;

  item_t                    item_q, item_d;
  status_e                  sts_q, sts_d;
  logic [YEAR_IW-1:0]       ny_q, ny_d;
  logic [MONTH_W-1:0]       nm_q, nm_d;
  logic [DAY_W-1:0]         nd_q, nd_d;
  logic signed [ORD_W-1:0]  ord_q, ord_d;
  logic [R_W-1:0]           r400_q, r400_d;
  logic [DIV_W-1:0]         dv_q, dv_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic [MONTH_W-1:0]       om_q, om_d;
  logic [DAY_W-1:0]         od_q, od_d;
  logic [YEAR_W-1:0]        oy_q, oy_d;
  status_e                  os_q, os_d;

  logic [DIV_W-3:0]         t12;
  logic [P12_W-1:0]         prod12;
  logic [QUO_W-1:0]         q12;
  logic [DIV_W-5:0]         t25;
  logic [P25_W-1:0]         prod25;
  logic [QUO_W-1:0]         q400;
  logic [DIV_W-1:0]         quo_ext, mul12, mul400, rem12, rem400;
  logic                     leap_now;
  logic                     leap_dec;
  logic [R_W-1:0]           r_inc, r_dec;
  logic [YEAR_IW-1:0]       ny_inc;
  logic signed [ORD_W-1:0]  ylen, ylen_dec, mlen;
  logic [MONTH_W-1:0]       div_month;
  logic                     feb29;
  logic                     out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign feb29    = (item_q.day == DAY_W'(29));

  always_comb begin
    // divide by 12 as a quarter divided by 3
    t12       = dv_q[DIV_W-1:2];
    prod12    = P12_W'(t12) * P12_W'(RECIP12);
    q12       = prod12[P12_W-1:RECIP12_SH];
    // divide by 400 as a sixteenth divided by 25
    t25       = dv_q[DIV_W-1:4];
    prod25    = P25_W'(t25) * P25_W'(RECIP25);
    q400      = QUO_W'(prod25[P25_W-1:RECIP25_SH]);
    quo_ext   = {{(DIV_W-QUO_W){1'b0}}, quo_q};
    mul12     = (quo_ext << 3) + (quo_ext << 2);
    mul400    = (quo_ext << 8) + (quo_ext << 7) + (quo_ext << 4);
    rem12     = dv_q - mul12;
    rem400    = dv_q - mul400;
    leap_now  = leap_of(r400_q);
    r_inc     = (r400_q == R_W'(R400_LAST)) ? '0 : r400_q + 1'b1;
    r_dec     = (r400_q == '0) ? R_W'(R400_LAST) : r400_q - 1'b1;
    leap_dec  = leap_of(r_dec);
    ny_inc    = ny_q + 1'b1;
    ylen      = $signed({{(ORD_W-DLEN_W){1'b0}}, year_len(leap_now)});
    ylen_dec  = $signed({{(ORD_W-DLEN_W){1'b0}}, year_len(leap_dec)});
    mlen      = $signed({{(ORD_W-DAY_W){1'b0}}, month_len(nm_q, leap_now)});
    div_month = rem12[MONTH_W-1:0] + 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    sts_d       = sts_q;
    ny_d        = ny_q;
    nm_d        = nm_q;
    nd_d        = nd_q;
    ord_d       = ord_q;
    r400_d      = r400_q;
    dv_d        = dv_q;
    quo_d       = quo_q;
    om_d        = om_q;
    od_d        = od_q;
    oy_d        = oy_q;
    os_d        = os_q;
    pop_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          item_d  = pop_item_i;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        sts_d = STS_OK;
        nm_d  = item_q.month;
        nd_d  = item_q.day;
        case (item_q.kind)
          K_BAD: begin
            sts_d   = STS_BAD_DATE;
            state_d = S_FINISH;
          end
          K_YEARS: begin
            if (item_q.sval < 0 || item_q.sval > MaxS) begin
              sts_d   = STS_RANGE;
              state_d = S_FINISH;
            end else begin
              ny_d = item_q.sval[YEAR_IW-1:0];
              if (item_q.month == MONTH_W'(2) && feb29) begin
                dv_d    = item_q.sval[DIV_W-1:0];
                state_d = S_MOD;
              end else begin
                state_d = S_FINISH;
              end
            end
          end
          K_MONTHS: begin
            if (item_q.sval < 0) begin
              sts_d   = STS_RANGE;
              state_d = S_FINISH;
            end else begin
              dv_d    = item_q.sval[DIV_W-1:0];
              state_d = S_DIV;
            end
          end
          K_DAYS: begin
            ny_d    = {{(YEAR_IW-YEAR_W){1'b0}}, item_q.year};
            dv_d    = {{(DIV_W-YEAR_W){1'b0}}, item_q.year};
            state_d = S_MOD;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_MOD: begin
        quo_d   = q400;
        state_d = S_REM;
      end
      S_REM: begin
        r400_d  = rem400[R_W-1:0];
        state_d = S_POST;
      end
      S_POST: begin
        if (item_q.kind == K_DAYS) begin
          ord_d = $signed({{(ORD_W-DAY_W){1'b0}}, item_q.day})
                  + $signed({{(ORD_W-DLEN_W){1'b0}}, days_before(item_q.month, leap_now)})
                  + $signed(item_q.sval[ORD_W-1:0]);
          state_d = S_WALK;
        end else begin
          if (!leap_now) begin
            nd_d = DAY_W'(28);
          end
          state_d = S_FINISH;
        end
      end
      S_DIV: begin
        quo_d   = q12;
        state_d = S_DIVDONE;
      end
      S_DIVDONE: begin
        ny_d = {{(YEAR_IW-QUO_W){1'b0}}, quo_q};
        nm_d = div_month;
        if ({{(YEAR_IW-QUO_W){1'b0}}, quo_q} > MaxU) begin
          sts_d   = STS_RANGE;
          state_d = S_FINISH;
        end else if (div_month == MONTH_W'(2) && feb29) begin
          dv_d    = {{(DIV_W-QUO_W){1'b0}}, quo_q};
          state_d = S_MOD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WALK: begin
        if (ord_q > ylen) begin
          ord_d  = ord_q - ylen;
          ny_d   = ny_inc;
          r400_d = r_inc;
          if (ny_inc > MaxU) begin
            sts_d   = STS_RANGE;
            state_d = S_FINISH;
          end
        end else if (ord_q < 1) begin
          if (ny_q == '0) begin
            sts_d   = STS_RANGE;
            state_d = S_FINISH;
          end else begin
            ny_d   = ny_q - 1'b1;
            r400_d = r_dec;
            ord_d  = ord_q + ylen_dec;
          end
        end else begin
          nm_d    = MONTH_W'(1);
          state_d = S_MWALK;
        end
      end
      S_MWALK: begin
        if (nm_q < MONTH_W'(12) && ord_q > mlen) begin
          ord_d = ord_q - mlen;
          nm_d  = nm_q + 1'b1;
        end else begin
          nd_d    = ord_q[DAY_W-1:0];
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          os_d        = sts_q;
          if (sts_q == STS_OK) begin
            om_d = nm_q;
            od_d = nd_q;
            oy_d = ny_q[YEAR_W-1:0];
          end else begin
            om_d = item_q.month;
            od_d = item_q.day;
            oy_d = item_q.year;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sts_q  <= sts_d;
    ny_q   <= ny_d;
    nm_q   <= nm_d;
    nd_q   <= nd_d;
    ord_q  <= ord_d;
    r400_q <= r400_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
    om_q   <= om_d;
    od_q   <= od_d;
    oy_q   <= oy_d;
    os_q   <= os_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_month_o = om_q;
  assign out_day_o   = od_q;
  assign out_year_o  = oy_q;
  assign status_o    = os_q;

  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STS_OK) |->
      (out_month_o >= MONTH_W'(1) && out_month_o <= MONTH_W'(12) && out_day_o != '0))
    else $error("ok result carries an impossible date");

  a_no_unit_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != STS_BAD_UNIT)
    else $error("unknown unit status reported");

  a_r400_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_MWALK) |-> r400_q <= R_W'(R400_LAST))
    else $error("year residue left its range");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_o && !out_ready_i) |=> state_q == S_FINISH)
    else $error("result dropped while output stalled");

  a_idle_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && pop_valid_i) |=> state_q == S_LOAD)
    else $error("queued item not taken");

endmodule

### design/calendar_date_offset_unit.sv
// The back end sequencer goes from load to finish for a bad date or a year out of range
// and for a year move, through the modulo 400 states when Feb 29 is checked; a month move
// passes the divide states and, when Feb 29 lands in February, the modulo 400 states; day
// and week moves pass the modulo 400 states and then walk years and months before finish.
// It takes one item at a time, with a 2 entry queue taking items ahead of it.
// Reset clears the queue, the sequencer and the output valid; no clearing pass.
`timescale 1ns / 1ps
module calendar_date_offset_unit
  import cdo_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [CNT_W-1:0]  count_i,
  input  logic [MONTH_W-1:0]       in_month_i,
  input  logic [DAY_W-1:0]         in_day_i,
  input  logic [YEAR_W-1:0]        in_year_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [MONTH_W-1:0]       out_month_o,
  output logic [DAY_W-1:0]         out_day_o,
  output logic [YEAR_W-1:0]        out_year_o,
  output logic [STS_W-1:0]         status_o
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  cdo_front #(
    .MAX_YEAR(MAX_YEAR)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .count_i     (count_i),
    .in_month_i  (in_month_i),
    .in_day_i    (in_day_i),
    .in_year_i   (in_year_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  cdo_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  cdo_back #(
    .MAX_YEAR(MAX_YEAR)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_item_i (pop_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_month_o(out_month_o),
    .out_day_o  (out_day_o),
    .out_year_o (out_year_o),
    .status_o   (status_o)
  );

endmodule

### sim/date_offset_checker.sv
// checker for the calendar date offset unit: predicts every date move and compares results
`timescale 1ns / 1ps
module date_offset_checker
  import cdo_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic signed [CNT_W-1:0] count_i,
  input  logic [MONTH_W-1:0]      in_month_i,
  input  logic [DAY_W-1:0]        in_day_i,
  input  logic [YEAR_W-1:0]       in_year_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [MONTH_W-1:0]      out_month_i,
  input  logic [DAY_W-1:0]        out_day_i,
  input  logic [YEAR_W-1:0]       out_year_i,
  input  logic [STS_W-1:0]        status_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    status_e            status;
  } date_result_t;

  date_result_t expected_dates[$];

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int m, int y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int days_in_year(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic date_result_t offset_date(cmd_e unit, int cnt, int m, int d, int y);
    date_result_t r;
    int nm;
    int nd;
    int ny;
    int ord;
    int total;
    int i;
    status_e st;
    nm = m;
    nd = d;
    ny = y;
    st = STS_OK;
    if (m < 1 || m > 12 || d < 1 || y > MAX_YEAR) begin
      st = STS_BAD_DATE;
    end else if (unit == CMD_YEAR) begin
      ny = y + cnt;
      if (ny < 0 || ny > MAX_YEAR) begin
        st = STS_RANGE;
      end else if (m == 2 && d == 29 && !is_leap(ny)) begin
        nd = 28;
      end
    end else if (unit == CMD_MONTH) begin
      total = y * 12 + (m - 1) + cnt;
      if (total < 0) begin
        st = STS_RANGE;
      end else begin
        ny = total / 12;
        nm = total % 12 + 1;
        if (ny > MAX_YEAR) begin
          st = STS_RANGE;
        end else if (nm == 2 && d == 29 && !is_leap(ny)) begin
          nd = 28;
        end
      end
    end else begin
      ord = d;
      for (i = 1; i < m; i++) ord += days_in_month(i, y);
      ord += (unit == CMD_WEEK) ? cnt * 7 : cnt;
      ny = y;
      while (st == STS_OK && ord > days_in_year(ny)) begin
        ord -= days_in_year(ny);
        ny++;
        if (ny > MAX_YEAR) st = STS_RANGE;
      end
      while (st == STS_OK && ord < 1) begin
        ny--;
        if (ny < 0) st = STS_RANGE;
        else ord += days_in_year(ny);
      end
      if (st == STS_OK) begin
        nm = 1;
        while (nm < 12 && ord > days_in_month(nm, ny)) begin
          ord -= days_in_month(nm, ny);
          nm++;
        end
        nd = ord;
      end
    end
    if (st != STS_OK) begin
      nm = m;
      nd = d;
      ny = y;
    end
    r.month  = nm[MONTH_W-1:0];
    r.day    = nd[DAY_W-1:0];
    r.year   = ny[YEAR_W-1:0];
    r.status = st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_result_t want;
    if (!rst_ni) begin
      expected_dates.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_dates.push_back(offset_date(cmd_e'(cmd_i), count_i, in_month_i, in_day_i,
                                             in_year_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          $error("result transfer with no date waiting");
          fail_count_o++;
        end else begin
          want = expected_dates.pop_front();
          if (out_month_i != want.month) begin
            $error("out_month: expected %0d, actual %0d", want.month, out_month_i);
            fail_count_o++;
          end
          if (out_day_i != want.day) begin
            $error("out_day: expected %0d, actual %0d", want.day, out_day_i);
            fail_count_o++;
          end
          if (out_year_i != want.year) begin
            $error("out_year: expected %0d, actual %0d", want.year, out_year_i);
            fail_count_o++;
          end
          if (status_i != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_dates.size();
    end
  end

endmodule

### sim/tb_calendar_date_offset_unit.sv
// testbench top for the calendar date offset unit: stimulus, back pressure and verdict
`timescale 1ns / 1ps
module tb_calendar_date_offset_unit;
  import cdo_pkg::*;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CMD_W-1:0]        cmd_i       = '0;
  logic signed [CNT_W-1:0] count_i     = '0;
  logic [MONTH_W-1:0]      in_month_i  = '0;
  logic [DAY_W-1:0]        in_day_i    = '0;
  logic [YEAR_W-1:0]       in_year_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [MONTH_W-1:0]      out_month_o;
  logic [DAY_W-1:0]        out_day_o;
  logic [YEAR_W-1:0]       out_year_o;
  logic [STS_W-1:0]        status_o;

  int fail_count;
  int dates_pending;
  int items_sent = 0;
  bit gaps_on    = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  calendar_date_offset_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .count_i     (count_i),
    .in_month_i  (in_month_i),
    .in_day_i    (in_day_i),
    .in_year_i   (in_year_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_month_o (out_month_o),
    .out_day_o   (out_day_o),
    .out_year_o  (out_year_o),
    .status_o    (status_o)
  );

  date_offset_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .count_i      (count_i),
    .in_month_i   (in_month_i),
    .in_day_i     (in_day_i),
    .in_year_i    (in_year_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_month_i  (out_month_o),
    .out_day_i    (out_day_o),
    .out_year_i   (out_year_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (dates_pending)
  );

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_date(input cmd_e c, input int n, input int m, input int d, input int y);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cmd_i      <= c;
    count_i    <= n[CNT_W-1:0];
    in_month_i <= m[MONTH_W-1:0];
    in_day_i   <= d[DAY_W-1:0];
    in_year_i  <= y[YEAR_W-1:0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && items_sent >= 400) begin
        // long hold so the unit fills up and stalls its input
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int   k;
    int   sel;
    cmd_e r_cmd;
    int   r_cnt;
    int   r_month;
    int   r_day;
    int   r_year;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_date(CMD_DAY, 1, 12, 31, 9998);
    send_date(CMD_DAY, 1, 12, 31, 9999);
    send_date(CMD_DAY, -1, 1, 1, 0);
    send_date(CMD_DAY, 0, 2, 30, 2001);
    send_date(CMD_DAY, 4095, 1, 1, 2000);
    send_date(CMD_DAY, -4096, 3, 1, 2000);
    send_date(CMD_WEEK, 4095, 1, 1, 1900);
    send_date(CMD_WEEK, -4096, 12, 31, 9999);
    send_date(CMD_WEEK, -4096, 6, 15, 50);
    send_date(CMD_MONTH, 1, 1, 29, 2001);
    send_date(CMD_MONTH, 12, 2, 29, 2000);
    send_date(CMD_MONTH, 1, 1, 31, 2001);
    send_date(CMD_MONTH, -1, 1, 15, 0);
    send_date(CMD_MONTH, 4095, 12, 1, 9999);
    send_date(CMD_MONTH, -4096, 1, 31, 9999);
    send_date(CMD_YEAR, 100, 2, 29, 2000);
    send_date(CMD_YEAR, 400, 2, 29, 2000);
    send_date(CMD_YEAR, -2000, 2, 29, 2000);
    send_date(CMD_YEAR, 4095, 7, 4, 9999);
    send_date(CMD_YEAR, -4096, 7, 4, 100);
    // bad input dates
    send_date(CMD_DAY, 5, 0, 10, 2020);
    send_date(CMD_WEEK, 5, 13, 10, 2020);
    send_date(CMD_MONTH, 5, 15, 31, 2020);
    send_date(CMD_YEAR, 5, 6, 0, 2020);
    send_date(CMD_DAY, -1, 12, 31, 16383);

    gaps_on = 1'b1;
    for (k = 0; k < 1850; k++) begin
      if (k == 1550) gaps_on = 1'b0;
      sel   = $urandom_range(0, 99);
      r_cmd = cmd_e'($urandom_range(0, 3));
      if (sel < 12) begin
        r_cnt   = $urandom();
        r_month = $urandom_range(0, 15);
        r_day   = $urandom_range(0, 31);
        r_year  = $urandom_range(0, 16383);
      end else begin
        r_month = $urandom_range(1, 12);
        r_day   = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
        case ($urandom_range(0, 5))
          0:       r_year = $urandom_range(0, 120);
          1:       r_year = $urandom_range(9880, 9999);
          default: r_year = $urandom_range(0, 9999);
        endcase
        case ($urandom_range(0, 4))
          0, 1:    r_cnt = $urandom_range(0, 80) - 40;
          2:       r_cnt = $urandom_range(0, 800) - 400;
          default: r_cnt = $urandom();
        endcase
      end
      send_date(r_cmd, r_cnt, r_month, r_day, r_year);
    end
    in_valid_i <= 1'b0;

    wait (dates_pending == 0);
    repeat (150) @(negedge clk_i);
    if (fail_count == 0 && dates_pending == 0) begin
      $display("tb_calendar_date_offset_unit: done, clean");
    end else begin
      $display("tb_calendar_date_offset_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_calendar_date_offset_unit: done, errors");
    $finish;
  end

endmodule

### files.f
design/cdo_pkg.sv
design/cdo_front.sv
design/cdo_queue.sv
design/cdo_back.sv
design/calendar_date_offset_unit.sv
sim/date_offset_checker.sv
sim/tb_calendar_date_offset_unit.sv
